// ----- rtl/spal_pkg.sv -----
// Shared types and constants for the slot pool with active list.
// Used by the controller, the datapath and the top level.
package spal_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int CMD_W         = 2;
   localparam int SLOT_W        = 6;
   localparam int STATUS_W      = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_END_OF_LIST = 2'd3;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_type;

endpackage

// ----- rtl/spal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/spal_ctrl.sv -----
// Controller: accept/execute sequencing and result valid flag.
// Depends on spal_pkg.
module spal_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spal_pkg::ctl_type ctl
);
   import spal_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign ctl.capture = req_valid && req_ready;
   assign ctl.execute = (state_ff == S_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = ctl.execute || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/spal_dpath.sv -----
// Datapath: link memories, head/tail and free-list registers, result register.
// Depends on spal_pkg and spal_ram.
module spal_dpath #(
   parameter int SLOTS = spal_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spal_pkg::ctl_type               ctl,
   input  logic [spal_pkg::CMD_W-1:0]      req_command,
   input  logic [spal_pkg::SLOT_W-1:0]     req_slot,
   input  logic                            req_from_head,
   output logic [spal_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spal_pkg::SLOT_W-1:0]     rsp_result_slot,
   output logic [spal_pkg::SLOT_W-1:0]     rsp_prev_slot,
   output logic                            rsp_prev_is_head
);
   import spal_pkg::*;

   localparam int PW  = $clog2(SLOTS + 1);
   localparam int AW  = $clog2(SLOTS);
   localparam int IU  = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
   localparam int IUW = $clog2(IU);
   localparam logic [PW-1:0] HEAD = PW'(SLOTS);

   logic [CMD_W-1:0]  cmd_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              from_head_ff;
   logic [PW-1:0]     free_top_ff, free_top_in;
   logic [PW-1:0]     fresh_ff, fresh_in;
   logic [PW-1:0]     head_next_ff, head_next_in;
   logic [PW-1:0]     head_prev_ff, head_prev_in;
   logic [IU-1:0]     in_use_ff, in_use_in;

   logic [STATUS_W-1:0] status_in;
   logic [SLOT_W-1:0]   result_in, prev_in;
   logic                prev_head_in;

   logic          next_we, prev_we, free_we;
   logic [AW-1:0] next_waddr, prev_waddr, free_waddr;
   logic [PW-1:0] next_wdata, prev_wdata, free_wdata;
   logic [PW-1:0] next_rdata, prev_rdata, free_rdata;

   logic          s_active;
   logic [PW-1:0] s_pw, n_of_s, p_of_s, t, tail, cur_next;
   logic          alloc_ok, rel_ok;

   spal_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next_mem (
      .clock (clock), .we (next_we), .waddr (next_waddr), .wdata (next_wdata),
      .re (ctl.capture), .raddr (AW'(req_slot)), .rdata (next_rdata)
   );

   spal_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prev_mem (
      .clock (clock), .we (prev_we), .waddr (prev_waddr), .wdata (prev_wdata),
      .re (ctl.capture), .raddr (AW'(req_slot)), .rdata (prev_rdata)
   );

   spal_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_free_mem (
      .clock (clock), .we (free_we), .waddr (free_waddr), .wdata (free_wdata),
      .re (ctl.capture), .raddr (AW'(free_top_ff)), .rdata (free_rdata)
   );

   assign s_pw     = PW'(slot_ff);
   assign s_active = (32'(slot_ff) < SLOTS) && in_use_ff[slot_ff[IUW-1:0]];
   // the tail's forward link is implied: it always points at the head
   assign n_of_s   = (s_pw == head_prev_ff) ? HEAD : next_rdata;
   assign p_of_s   = prev_rdata;
   assign t        = free_top_ff;
   assign tail     = head_prev_ff;
   assign cur_next = from_head_ff ? head_next_ff : n_of_s;
   assign alloc_ok = ctl.execute && (cmd_ff == CMD_ALLOC) && (t != HEAD);
   assign rel_ok   = ctl.execute && (cmd_ff == CMD_RELEASE) && s_active;

   always_comb begin
      free_top_in  = free_top_ff;
      fresh_in     = fresh_ff;
      head_next_in = head_next_ff;
      head_prev_in = head_prev_ff;
      in_use_in    = in_use_ff;
      next_we      = 1'b0;
      prev_we      = 1'b0;
      free_we      = 1'b0;
      next_waddr   = AW'(tail);
      next_wdata   = t;
      prev_waddr   = AW'(t);
      prev_wdata   = tail;
      free_waddr   = AW'(s_pw);
      free_wdata   = free_top_ff;
      status_in    = ST_OK;
      result_in    = '0;
      prev_in      = '0;
      prev_head_in = 1'b0;

      case (cmd_ff)
         CMD_ALLOC: begin
            if (t == HEAD) begin
               status_in = ST_POOL_EMPTY;
            end else begin
               result_in = SLOT_W'(t);
               if (alloc_ok) begin
                  // untouched region of the free list links to the next index
                  if (t == fresh_ff) begin
                     free_top_in = t + PW'(1);
                     fresh_in    = fresh_ff + PW'(1);
                  end else begin
                     free_top_in = free_rdata;
                  end
                  prev_we = 1'b1;
                  if (tail == HEAD) head_next_in = t;
                  else next_we = 1'b1;
                  head_prev_in = t;
                  if (32'(t) < IU) in_use_in[IUW'(t)] = 1'b1;
               end
            end
         end
         CMD_RELEASE: begin
            if (!s_active) begin
               status_in = ST_NOT_ACTIVE;
            end else begin
               prev_head_in = (p_of_s == HEAD);
               prev_in      = (p_of_s == HEAD) ? '0 : SLOT_W'(p_of_s);
               if (rel_ok) begin
                  next_waddr = AW'(p_of_s);
                  next_wdata = n_of_s;
                  prev_waddr = AW'(n_of_s);
                  prev_wdata = p_of_s;
                  if (p_of_s == HEAD) head_next_in = n_of_s;
                  else next_we = 1'b1;
                  if (n_of_s == HEAD) head_prev_in = p_of_s;
                  else prev_we = 1'b1;
                  free_we     = 1'b1;
                  free_top_in = s_pw;
                  in_use_in[slot_ff[IUW-1:0]] = 1'b0;
               end
            end
         end
         CMD_NEXT: begin
            if (!from_head_ff && !s_active) begin
               status_in = ST_NOT_ACTIVE;
            end else if (cur_next == HEAD) begin
               status_in = ST_END_OF_LIST;
            end else begin
               result_in = SLOT_W'(cur_next);
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff  <= '0;
         fresh_ff     <= '0;
         head_next_ff <= HEAD;
         head_prev_ff <= HEAD;
         in_use_ff    <= '0;
      end else if (ctl.execute) begin
         free_top_ff  <= free_top_in;
         fresh_ff     <= fresh_in;
         head_next_ff <= head_next_in;
         head_prev_ff <= head_prev_in;
         in_use_ff    <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff       <= req_command;
         slot_ff      <= req_slot;
         from_head_ff <= req_from_head;
      end
      if (ctl.execute) begin
         rsp_status       <= status_in;
         rsp_result_slot  <= result_in;
         rsp_prev_slot    <= prev_in;
         rsp_prev_is_head <= prev_head_in;
      end
   end

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (head_next_ff == HEAD) == (head_prev_ff == HEAD))
      else $error("head and tail disagree on empty list");

   a_free_top_bound: assert property (@(posedge clock) disable iff (reset)
      (free_top_ff <= fresh_ff) || (free_top_ff == HEAD))
      else $error("free top beyond fresh region");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fresh_ff) <= SLOTS)
      else $error("fresh count overflow");

   a_alloc_moves_tail: assert property (@(posedge clock) disable iff (reset)
      alloc_ok |=> (head_prev_ff == $past(t)))
      else $error("allocated slot not at tail");

endmodule

// ----- rtl/slot_pool_with_active_list.sv -----
// Top level of the slot pool with active list.
// Depends on spal_pkg, spal_ctrl, spal_dpath (which uses spal_ram).
//
// Commands arrive on the req_ channel (valid/ready); each gives exactly one
// result on the rsp_ channel. Allocate pops the free-list top and appends it
// at the active tail; release unlinks an active slot, pushes it on the free
// list and reports its predecessor; next returns the active slot after a
// cursor or after the head.
// The link RAMs are read at the accepting edge; the result register then
// loads in the execute step once it is free, and rsp_valid rises with it.
// A new command is accepted only from the idle step, so each command
// finishes the read-then-write pass over the single-port-write link RAMs
// before another is taken.
// A result waiting on rsp_ does not block acceptance of the next command;
// if the receiver still stalls when that command finishes, the block waits
// in its execute step until the result register frees.
// Reset (synchronous) empties the active list and restores the free list
// in index order from 0; no clearing pass over the RAMs is needed.
module slot_pool_with_active_list #(
   parameter int SLOTS = spal_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [spal_pkg::CMD_W-1:0]    req_command,
   input  logic [spal_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          req_from_head,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spal_pkg::STATUS_W-1:0] rsp_status,
   output logic [spal_pkg::SLOT_W-1:0]   rsp_result_slot,
   output logic [spal_pkg::SLOT_W-1:0]   rsp_prev_slot,
   output logic                          rsp_prev_is_head
);
   import spal_pkg::*;

   ctl_type ctl;

   spal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   spal_dpath #(.SLOTS(SLOTS)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_from_head    (req_from_head),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_prev_slot    (rsp_prev_slot),
      .rsp_prev_is_head (rsp_prev_is_head)
   );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for slot_pool_with_active_list: directed and random
// allocate, release, next and walk traffic, checked by a linked-list predictor.
// Depends on spal_pkg and the slot_pool_with_active_list RTL.
module testbench;
   import spal_pkg::*;

   localparam int POOL = SLOTS_DEFAULT;
   localparam int HEAD = POOL;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int RUN_LIMIT = 4000000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   result_slot;
      logic [SLOT_W-1:0]   prev_slot;
      logic                prev_is_head;
   } pool_response_type;

   class slot_pool_tracker_type;
      int next_link [0:POOL];
      int prev_link [0:POOL];
      int free_link [0:POOL-1];
      int free_top;
      bit in_use [0:POOL-1];
      pool_response_type pending_q [$];
      int errors;

      function new();
         int i;
         for (i = 0; i <= POOL; i++) begin
            next_link[i] = 0;
            prev_link[i] = 0;
         end
         next_link[HEAD] = HEAD;
         prev_link[HEAD] = HEAD;
         for (i = 0; i < POOL; i++) begin
            free_link[i] = i + 1;
            in_use[i] = 1'b0;
         end
         free_top = 0;
         errors = 0;
      endfunction

      function pool_response_type accept_command(logic [CMD_W-1:0] cmd,
                                                 logic [SLOT_W-1:0] slot,
                                                 logic from_head);
         pool_response_type r;
         int t, p, n, cur, s;
         r = '0;
         s = int'(slot);
         case (cmd)
            CMD_ALLOC: begin
               if (free_top >= POOL) begin
                  r.status = ST_POOL_EMPTY;
               end else begin
                  t = free_top;
                  free_top = free_link[t];
                  p = prev_link[HEAD];
                  if (p > POOL) p = HEAD;
                  prev_link[t] = p;
                  next_link[t] = HEAD;
                  next_link[p] = t;
                  prev_link[HEAD] = t;
                  in_use[t] = 1'b1;
                  r.result_slot = t[SLOT_W-1:0];
               end
            end
            CMD_RELEASE: begin
               if (s >= POOL || !in_use[s]) begin
                  r.status = ST_NOT_ACTIVE;
               end else begin
                  p = prev_link[s];
                  n = next_link[s];
                  if (p > POOL) p = HEAD;
                  if (n > POOL) n = HEAD;
                  next_link[p] = n;
                  prev_link[n] = p;
                  next_link[s] = 0;
                  prev_link[s] = 0;
                  in_use[s] = 1'b0;
                  free_link[s] = free_top;
                  free_top = s;
                  if (p == HEAD) r.prev_is_head = 1'b1;
                  else r.prev_slot = p[SLOT_W-1:0];
               end
            end
            CMD_NEXT: begin
               if (!from_head && (s >= POOL || !in_use[s])) begin
                  r.status = ST_NOT_ACTIVE;
               end else begin
                  cur = from_head ? HEAD : s;
                  n = next_link[cur];
                  if (n >= POOL) r.status = ST_END_OF_LIST;
                  else r.result_slot = n[SLOT_W-1:0];
               end
            end
            default: begin
               r = '0;
            end
         endcase
         pending_q.push_back(r);
         return r;
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(pool_response_type got);
         pool_response_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected transfer, status %0d result_slot %0d",
                     $time, got.status, got.result_slot);
            $display("%0t: unexpected transfer, prev_slot %0d prev_is_head %0d",
                     $time, got.prev_slot, got.prev_is_head);
            errors++;
         end else begin
            want = pending_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("result_slot", want.result_slot, got.result_slot);
            compare_field("prev_slot", want.prev_slot, got.prev_slot);
            compare_field("prev_is_head", want.prev_is_head, got.prev_is_head);
         end
      endfunction

      function int pending_count();
         return pending_q.size();
      endfunction

      function int pick_active_slot();
         int found [$];
         foreach (in_use[i]) if (in_use[i]) found.push_back(i);
         if (found.size() == 0) return -1;
         return found[$urandom_range(0, found.size() - 1)];
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic [SLOT_W-1:0]   req_slot;
   logic                req_from_head;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_result_slot;
   logic [SLOT_W-1:0]   rsp_prev_slot;
   logic                rsp_prev_is_head;

   slot_pool_tracker_type tracker = new();
   int items_sent = 0;
   bit sender_idling = 1'b1;
   bit receiver_idling = 1'b1;
   bit stall_request = 1'b0;

   slot_pool_with_active_list uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_from_head    (req_from_head),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_prev_slot    (rsp_prev_slot),
      .rsp_prev_is_head (rsp_prev_is_head)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : response_monitor
      pool_response_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.result_slot = rsp_result_slot;
         got.prev_slot = rsp_prev_slot;
         got.prev_is_head = rsp_prev_is_head;
         tracker.check_response(got);
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int burst;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // leaves req_valid high after the transfer so back-to-back commands need no bubble
   task send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                     input logic from_head, output pool_response_type predicted);
      int gap;
      gap = (sender_idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_slot <= slot;
      req_from_head <= from_head;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = tracker.accept_command(cmd, slot, from_head);
      items_sent++;
   endtask

   task stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task wait_for_drain();
      stop_sending();
      while (tracker.pending_count() != 0) @(posedge clock);
   endtask

   // follows the active list from the head, sometimes releasing the current slot
   task walk_list();
      pool_response_type r;
      int steps;
      steps = 0;
      send_command(CMD_NEXT, 6'($urandom_range(0, 63)), 1'b1, r);
      while (r.status == ST_OK && steps < 80) begin
         if ($urandom_range(0, 3) == 0) begin
            send_command(CMD_RELEASE, r.result_slot, 1'($urandom_range(0, 1)), r);
            if (r.prev_is_head) send_command(CMD_NEXT, 6'($urandom_range(0, 63)), 1'b1, r);
            else send_command(CMD_NEXT, r.prev_slot, 1'b0, r);
         end else begin
            send_command(CMD_NEXT, r.result_slot, 1'b0, r);
         end
         steps++;
      end
   endtask

   task random_action(input int alloc_pct, input int release_pct);
      pool_response_type r;
      int pick, active;
      pick = $urandom_range(0, 99);
      active = tracker.pick_active_slot();
      if (pick < alloc_pct) begin
         send_command(CMD_ALLOC, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), r);
      end else if (pick < alloc_pct + release_pct) begin
         if (active >= 0 && $urandom_range(0, 5) != 0)
            send_command(CMD_RELEASE, 6'(active), 1'($urandom_range(0, 1)), r);
         else
            send_command(CMD_RELEASE, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), r);
      end else if (pick < 94) begin
         case ($urandom_range(0, 3))
            0: send_command(CMD_NEXT, 6'($urandom_range(0, 63)), 1'b1, r);
            1: send_command(CMD_NEXT, 6'($urandom_range(0, 63)), 1'b0, r);
            default: begin
               if (active >= 0) send_command(CMD_NEXT, 6'(active), 1'b0, r);
               else send_command(CMD_NEXT, 6'($urandom_range(0, 63)), 1'b0, r);
            end
         endcase
      end else if (pick < 98) begin
         walk_list();
      end else begin
         send_command(CMD_UNUSED, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), r);
      end
   endtask

   initial begin : stimulus
      pool_response_type r;
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_ALLOC;
      req_slot = '0;
      req_from_head = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list, bad cursors, unused command
      send_command(CMD_NEXT, 6'd0, 1'b1, r);
      send_command(CMD_NEXT, 6'd63, 1'b1, r);
      send_command(CMD_RELEASE, 6'd0, 1'b0, r);
      send_command(CMD_NEXT, 6'd5, 1'b0, r);
      send_command(CMD_UNUSED, 6'd63, 1'b1, r);
      // build and walk a short list
      send_command(CMD_ALLOC, 6'd63, 1'b1, r);
      send_command(CMD_ALLOC, 6'd0, 1'b0, r);
      send_command(CMD_ALLOC, 6'd42, 1'b0, r);
      send_command(CMD_NEXT, 6'd21, 1'b1, r);
      send_command(CMD_NEXT, 6'd0, 1'b0, r);
      send_command(CMD_NEXT, 6'd2, 1'b0, r);
      // release from the middle, then the first, then the last
      send_command(CMD_RELEASE, 6'd1, 1'b1, r);
      send_command(CMD_RELEASE, 6'd0, 1'b0, r);
      send_command(CMD_RELEASE, 6'd2, 1'b0, r);
      send_command(CMD_RELEASE, 6'd2, 1'b0, r);
      send_command(CMD_NEXT, 6'd0, 1'b1, r);
      send_command(CMD_ALLOC, 6'd0, 1'b0, r);
      send_command(CMD_RELEASE, 6'd63, 1'b1, r);
      send_command(CMD_NEXT, 6'd63, 1'b0, r);

      // allocation-heavy: fills the pool and hits the empty case
      while (items_sent < 320) random_action(60, 20);

      // long receiver hold-off while commands keep coming
      stall_request = 1'b1;
      repeat (40) random_action(45, 30);
      wait_for_drain();

      // release-heavy with walks
      while (items_sent < 650) random_action(30, 45);

      // no idling on either side
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      while (items_sent < 780) random_action(45, 35);

      stop_sending();
      waited = 0;
      while (tracker.pending_count() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (tracker.pending_count() != 0) begin
         $display("%0t: %0d expected transfers never arrived", $time, tracker.pending_count());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("slot_pool_with_active_list test passed");
      end else begin
         $display("slot_pool_with_active_list test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("%0t: timeout", $time);
      $display("slot_pool_with_active_list test failed");
      $finish;
   end

endmodule
